FILE: hdl/occupation_string_rank_unrank_assert.svh
// ----------------------------------------------------------------------------
// Occupation string rank/unrank assertion macros
// Shared property forms for the rank/unrank block checks.
// ----------------------------------------------------------------------------
`ifndef OCCUPATION_STRING_RANK_UNRANK_ASSERT_SVH
`define OCCUPATION_STRING_RANK_UNRANK_ASSERT_SVH

// same-cycle implication
`define OSRU_ASSERT_IMP(label, clk_sig, rstn_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
		else $error("osru assertion failed");

// next-cycle implication
`define OSRU_ASSERT_NXT(label, clk_sig, rstn_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
		else $error("osru assertion failed");

`endif

FILE: hdl/osru_pkg.sv
// ----------------------------------------------------------------------------
// osru_pkg
// Widths, register indexes and cell operation codes of the rank/unrank block.
// ----------------------------------------------------------------------------
`default_nettype none

package osru_pkg;

	localparam int VAL_W     = 30;	// binomial values, ranks
	localparam int OCC_W     = 32;	// occupation string
	localparam int CFG_W     = 6;	// configuration registers
	localparam int REG_IDX_W = 1;

	localparam int DEF_MAX_ORBITALS  = 32;
	localparam int DEF_MAX_ELECTRONS = 32;

	typedef logic [REG_IDX_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_ELECTRONS = 1'b0;
	localparam reg_idx_t REG_ORBITALS  = 1'b1;

	localparam logic OP_RANK   = 1'b0;
	localparam logic OP_UNRANK = 1'b1;

	typedef logic [2:0] cell_op_t;
	localparam cell_op_t CELL_HOLD  = 3'd0;
	localparam cell_op_t CELL_LOAD  = 3'd1;
	localparam cell_op_t CELL_ADD   = 3'd2;	// Pascal row step: own + neighbor
	localparam cell_op_t CELL_SUB   = 3'd3;	// column step down in t, with shift
	localparam cell_op_t CELL_SHIFT = 3'd4;	// take neighbor value

endpackage

`default_nettype wire

FILE: hdl/occupation_string_rank_unrank.sv
// ----------------------------------------------------------------------------
// occupation_string_rank_unrank
// Lexical address of an occupation string and its inverse, computed by a
// chain of binomial cells that walks the orbitals one per cycle.
// ----------------------------------------------------------------------------
//
//  channel   signals                                  handshake
//  -------   ---------------------------------------  ----------------------
//  input     op, occupation_in, rank_in               start & !busy
//  result    rank_out, occupation_out, error          done, one cycle
//  config    wr_index, wr_data                        wr_en, no wait
//
//  An item is loaded into the chain at the accepting edge, walks one orbital
//  per cycle in ST_WALK and then passes ST_FIN, which registers the result;
//  done rises as ST_FIN ends. An item refused at accept goes straight to
//  ST_FIN. busy falls with done, so the next item is taken at the edge that
//  ends the done cycle. After reset and after each register write the seed
//  column C(d,electrons) is rebuilt in ST_SEED_LOAD and ST_SEED, busy high.
//  The receiver cannot stall; done is a one-cycle strobe.
//
// ----------------------------------------------------------------------------
`default_nettype none

module occupation_string_rank_unrank #(
	parameter int MAX_ORBITALS  = osru_pkg::DEF_MAX_ORBITALS,
	parameter int MAX_ELECTRONS = osru_pkg::DEF_MAX_ELECTRONS
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              wr_en,
	input  wire osru_pkg::reg_idx_t          wr_index,
	input  wire [osru_pkg::CFG_W-1:0]        wr_data,
	input  wire                              start,
	output logic                             busy,
	input  wire                              op,
	input  wire [osru_pkg::OCC_W-1:0]        occupation_in,
	input  wire [osru_pkg::VAL_W-1:0]        rank_in,
	output logic                             done,
	output logic [osru_pkg::VAL_W-1:0]       rank_out,
	output logic [osru_pkg::OCC_W-1:0]       occupation_out,
	output logic                             error
);
	import osru_pkg::*;

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_SEED_LOAD = 3'd1;
	localparam logic [2:0] ST_SEED      = 3'd2;
	localparam logic [2:0] ST_WALK      = 3'd3;
	localparam logic [2:0] ST_FIN       = 3'd4;

	logic [2:0]                          state_q;
	logic [CFG_W-1:0]                    electrons_q;
	logic [CFG_W-1:0]                    orbitals_q;
	logic [MAX_ORBITALS-1:0][VAL_W-1:0]  seed_q;
	logic [VAL_W-1:0]                    count_q;
	logic [CFG_W-1:0]                    cnt_q;
	logic [CFG_W-1:0]                    t_q;
	logic [VAL_W-1:0]                    acc_q;
	logic [OCC_W-1:0]                    occ_q;
	logic [OCC_W-1:0]                    mask_q;
	logic [OCC_W-1:0]                    res_q;
	logic                                op_q;
	logic                                err_q;
	logic                                done_q;
	logic [VAL_W-1:0]                    rank_out_q;
	logic [OCC_W-1:0]                    occ_out_q;
	logic                                error_q;

	logic                                accept;
	logic                                cfg_ok;
	logic                                early_err;
	logic                                walk_last;
	logic                                seed_last;
	logic                                bit_set;
	logic                                tstep;
	logic                                fin_err;
	cell_op_t                            cell_op;
	logic [MAX_ORBITALS-1:0][VAL_W-1:0]  onehot;
	logic [MAX_ORBITALS-1:0][VAL_W-1:0]  load_vals;
	logic [VAL_W-1:0]                    top_val;
	logic [VAL_W-1:0]                    head;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign cfg_ok = (electrons_q != '0) &&
			(electrons_q <= CFG_W'(MAX_ELECTRONS)) &&
			(orbitals_q <= CFG_W'(MAX_ORBITALS)) &&
			(orbitals_q >= electrons_q);

	assign early_err = !cfg_ok ||
			((op == OP_RANK) ? ((occupation_in >> orbitals_q) != '0)
					 : (rank_in >= count_q));

	assign walk_last = (cnt_q == orbitals_q - CFG_W'(1));
	assign seed_last = (cnt_q == orbitals_q);

	// head holds C(orbitals-1-o, t) while walking orbital o
	assign bit_set = (op_q == OP_UNRANK) ? ((t_q != '0) && (head <= acc_q)) : occ_q[0];
	assign tstep   = bit_set && (t_q != '0);
	assign fin_err = err_q || ((op_q == OP_RANK) && (t_q != '0));

	// Pascal row at d = 0: cell i holds C(0, electrons-i)
	for (genvar i = 0; i < MAX_ORBITALS; i++) begin : g_onehot
		assign onehot[i] = (electrons_q == CFG_W'(i)) ? VAL_W'(1) : '0;
	end

	assign load_vals = (state_q == ST_SEED_LOAD) ? onehot : seed_q;
	assign top_val   = ((state_q == ST_SEED) && (electrons_q == CFG_W'(MAX_ORBITALS)))
			 ? VAL_W'(1) : '0;

	always_comb begin
		cell_op = CELL_HOLD;
		unique case (state_q)
			ST_SEED_LOAD: cell_op = CELL_LOAD;
			ST_SEED:      cell_op = seed_last ? CELL_HOLD : CELL_ADD;
			ST_WALK:      cell_op = tstep ? CELL_SUB : CELL_SHIFT;
			ST_IDLE:      cell_op = accept ? CELL_LOAD : CELL_HOLD;
			default:      cell_op = CELL_HOLD;
		endcase
	end

	osru_chain #(
		.CELLS (MAX_ORBITALS)
	) u_chain (
		.clk       (clk),
		.op        (cell_op),
		.load_vals (load_vals),
		.top_val   (top_val),
		.head      (head)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SEED_LOAD;
			electrons_q <= CFG_W'(1);
			orbitals_q  <= CFG_W'(1);
			done_q      <= 1'b0;
		end else begin
			done_q <= !wr_en && (state_q == ST_FIN);
			if (wr_en) begin
				unique case (wr_index)
					REG_ELECTRONS: electrons_q <= wr_data;
					REG_ORBITALS:  orbitals_q  <= wr_data;
					default:       electrons_q <= electrons_q;
				endcase
				state_q <= ST_SEED_LOAD;
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						if (accept) begin
							state_q <= early_err ? ST_FIN : ST_WALK;
						end
					end
					ST_SEED_LOAD: state_q <= ST_SEED;
					ST_SEED: begin
						if (seed_last) begin
							state_q <= ST_IDLE;
						end
					end
					ST_WALK: begin
						if (walk_last) begin
							state_q <= ST_FIN;
						end
					end
					ST_FIN: begin
						state_q <= ST_IDLE;
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_SEED_LOAD: cnt_q <= '0;
			ST_SEED: begin
				if (seed_last) begin
					count_q <= head;
				end else begin
					seed_q <= {seed_q[MAX_ORBITALS-2:0], head};
					cnt_q  <= cnt_q + CFG_W'(1);
				end
			end
			ST_IDLE: begin
				if (accept) begin
					op_q   <= op;
					occ_q  <= occupation_in;
					mask_q <= OCC_W'(1);
					res_q  <= '0;
					t_q    <= electrons_q;
					cnt_q  <= '0;
					err_q  <= early_err;
					// unrank walks the complement address greedily
					acc_q  <= (op == OP_UNRANK) ? (count_q - VAL_W'(1) - rank_in) : '0;
				end
			end
			ST_WALK: begin
				if (tstep) begin
					t_q <= t_q - CFG_W'(1);
					if (op_q == OP_UNRANK) begin
						acc_q <= acc_q - head;
						res_q <= res_q | mask_q;
					end else begin
						acc_q <= acc_q + head;
					end
				end
				// too many set bits
				if ((op_q == OP_RANK) && occ_q[0] && (t_q == '0)) begin
					err_q <= 1'b1;
				end
				occ_q  <= occ_q >> 1;
				mask_q <= mask_q << 1;
				cnt_q  <= cnt_q + CFG_W'(1);
			end
			ST_FIN: begin
				error_q <= fin_err;
				rank_out_q <= (fin_err || (op_q == OP_UNRANK)) ? '0
						: (count_q - VAL_W'(1) - acc_q);
				occ_out_q  <= (fin_err || (op_q == OP_RANK)) ? '0 : res_q;
			end
			default: cnt_q <= cnt_q;
		endcase
	end

	assign done           = done_q;
	assign rank_out       = rank_out_q;
	assign occupation_out = occ_out_q;
	assign error          = error_q;

	`include "occupation_string_rank_unrank_assert.svh"

	`OSRU_ASSERT_NXT(a_done_after_fin, clk, arst_n, state_q == ST_FIN && !wr_en, done_q)
	`OSRU_ASSERT_IMP(a_err_zero, clk, arst_n, done_q && error_q, rank_out_q == '0 && occ_out_q == '0)
	`OSRU_ASSERT_IMP(a_tstep_live, clk, arst_n, state_q == ST_WALK && tstep, t_q != '0)
	`OSRU_ASSERT_NXT(a_accept_busy, clk, arst_n, accept && !wr_en, busy)

endmodule

`default_nettype wire

FILE: hdl/osru_cell.sv
// ----------------------------------------------------------------------------
// osru_cell
// One binomial cell: holds a value that it loads or updates from its upper neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module osru_cell (
	input  wire                          clk,
	input  wire osru_pkg::cell_op_t      op,
	input  wire [osru_pkg::VAL_W-1:0]    load_val,
	input  wire [osru_pkg::VAL_W-1:0]    next_val,
	output logic [osru_pkg::VAL_W-1:0]   val
);
	import osru_pkg::*;

	logic [VAL_W-1:0] val_q;

	always_ff @(posedge clk) begin
		unique case (op)
			CELL_LOAD:  val_q <= load_val;
			CELL_ADD:   val_q <= val_q + next_val;
			CELL_SUB:   val_q <= val_q - next_val;
			CELL_SHIFT: val_q <= next_val;
			default:    val_q <= val_q;
		endcase
	end

	assign val = val_q;

endmodule

`default_nettype wire

FILE: hdl/osru_chain.sv
// ----------------------------------------------------------------------------
// osru_chain
// Row of binomial cells, one per orbital, each fed by its upper neighbor, the top one by top_val.
// ----------------------------------------------------------------------------
`default_nettype none

module osru_chain #(
	parameter int CELLS = osru_pkg::DEF_MAX_ORBITALS
) (
	input  wire                                     clk,
	input  wire osru_pkg::cell_op_t                 op,
	input  wire [CELLS-1:0][osru_pkg::VAL_W-1:0]    load_vals,
	input  wire [osru_pkg::VAL_W-1:0]               top_val,
	output logic [osru_pkg::VAL_W-1:0]              head
);
	import osru_pkg::*;

	logic [CELLS-1:0][VAL_W-1:0] vals;
	logic [CELLS-1:0][VAL_W-1:0] nexts;

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		if (i == CELLS - 1) begin : g_top
			assign nexts[i] = top_val;
		end else begin : g_mid
			assign nexts[i] = vals[i+1];
		end

		osru_cell u_cell (
			.clk      (clk),
			.op       (op),
			.load_val (load_vals[i]),
			.next_val (nexts[i]),
			.val      (vals[i])
		);
	end

	assign head = vals[0];

endmodule

`default_nettype wire
